/* rtl/dff_pkg.sv */
package dff_pkg;

  localparam int FRAME_HALF_BITS = 56;
  localparam int IDX_W = $clog2(FRAME_HALF_BITS + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FRAME_HALF_BITS);

  localparam int CNT_W = 8;
  localparam logic [CNT_W-1:0] TX_WAIT_RESET = 8'd20;
  localparam logic [CNT_W-1:0] RECEIVE_RESET = 8'd24;
  localparam logic [CNT_W-1:0] RX_WAIT_RESET = 8'd6;

  // command codes on the input word
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_SEND  = 2'd1;
  localparam logic [1:0] CMD_LEVEL = 2'd2;

  // register indexes on the configuration port
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_TX_WAIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECEIVE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RX_WAIT = 2'd2;

  localparam int IN_W  = 32;
  localparam int OUT_W = 8;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_TICK,
    KIND_SEND
  } kind_t;

  typedef struct packed {
    kind_t                      kind;
    logic [FRAME_HALF_BITS-1:0] frame;
  } entry_t;

  typedef struct packed {
    logic busy_res;
    logic status;
    logic line_written;
    logic line_level;
  } result_t;

  // bit 0 -> 10, bit 1 -> 01, low half-bit first
  function automatic logic [31:0] manchester16(input logic [15:0] v);
    logic [31:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      r[2*i +: 2] = v[i] ? 2'b01 : 2'b10;
    end
    return r;
  endfunction

endpackage

/* rtl/dff_queue.sv */
module dff_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  dff_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output dff_pkg::entry_t pop_data,
  output logic            empty
);
  import dff_pkg::*;

  entry_t              mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign full     = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/dff_front.sv */
module dff_front (
  input  logic [1:0]      command,
  input  logic [7:0]      target_addr,
  input  logic [15:0]     payload,
  output dff_pkg::entry_t entry
);
  import dff_pkg::*;

  logic [31:0] addr_enc;
  logic [31:0] pay_enc;
  logic [1:0]  y_pair;
  logic [1:0]  s_pair;

  always_comb begin
    addr_enc = manchester16({10'd0, target_addr[5:0]});
    pay_enc  = manchester16(payload);
    y_pair   = 2'b10;
    s_pair   = 2'b10;
    entry.kind = KIND_NONE;
    case (command)
      CMD_TICK: begin
        entry.kind = KIND_TICK;
      end
      CMD_SEND: begin
        entry.kind = KIND_SEND;
        y_pair = target_addr[7] ? 2'b01 : 2'b10;
        s_pair = 2'b01;
      end
      CMD_LEVEL: begin
        entry.kind = KIND_SEND;
      end
      default: begin
        entry.kind = KIND_NONE;
      end
    endcase
    // stop, payload, s, address, y, start
    entry.frame = {6'h3F, pay_enc, s_pair, addr_enc[11:0], y_pair, 2'b01};
  end

endmodule

/* rtl/dff_back.sv */
module dff_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [dff_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dff_pkg::CNT_W-1:0]       cfg_data,
  input  logic                            q_empty,
  input  dff_pkg::entry_t                 q_data,
  output logic                            q_pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output dff_pkg::result_t                out_data
);
  import dff_pkg::*;

  logic [CNT_W-1:0] tx_wait_ticks;
  logic [CNT_W-1:0] receive_ticks;
  logic [CNT_W-1:0] rx_wait_ticks;

  logic                       busy;
  logic [IDX_W-1:0]           idx;
  logic [FRAME_HALF_BITS-1:0] frame;
  logic [CNT_W-1:0]           tx_cnt;
  logic [CNT_W-1:0]           rcv_cnt;
  logic [CNT_W-1:0]           rx_cnt;

  logic                       busy_next;
  logic [IDX_W-1:0]           idx_next;
  logic [FRAME_HALF_BITS-1:0] frame_next;
  logic [CNT_W-1:0]           tx_cnt_next;
  logic [CNT_W-1:0]           rcv_cnt_next;
  logic [CNT_W-1:0]           rx_cnt_next;
  result_t                    res;

  assign q_pop = !q_empty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_wait_ticks <= TX_WAIT_RESET;
      receive_ticks <= RECEIVE_RESET;
      rx_wait_ticks <= RX_WAIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TX_WAIT: tx_wait_ticks <= cfg_data;
        REG_RECEIVE: receive_ticks <= cfg_data;
        REG_RX_WAIT: rx_wait_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    busy_next    = busy;
    idx_next     = idx;
    frame_next   = frame;
    tx_cnt_next  = tx_cnt;
    rcv_cnt_next = rcv_cnt;
    rx_cnt_next  = rx_cnt;
    res          = '0;
    case (q_data.kind)
      KIND_SEND: begin
        if (busy) begin
          res.status = 1'b1;
        end else begin
          // first half-bit goes out with the request itself
          res.line_level   = q_data.frame[0];
          res.line_written = 1'b1;
          frame_next   = q_data.frame >> 1;
          idx_next     = IDX_W'(1);
          busy_next    = 1'b1;
          tx_cnt_next  = tx_wait_ticks;
          rcv_cnt_next = receive_ticks;
          rx_cnt_next  = rx_wait_ticks;
        end
      end
      KIND_TICK: begin
        if (busy) begin
          if (idx < IDX_LAST) begin
            res.line_level   = frame[0];
            res.line_written = 1'b1;
            frame_next = frame >> 1;
            idx_next   = idx + 1'b1;
          end else if (tx_cnt != '0) begin
            tx_cnt_next = tx_cnt - 1'b1;
          end else if (rcv_cnt != '0) begin
            rcv_cnt_next = rcv_cnt - 1'b1;
          end else if (rx_cnt != '0) begin
            rx_cnt_next = rx_cnt - 1'b1;
          end else begin
            idx_next     = '0;
            busy_next    = 1'b0;
            tx_cnt_next  = tx_wait_ticks;
            rcv_cnt_next = receive_ticks;
            rx_cnt_next  = rx_wait_ticks;
          end
        end
      end
      default: begin
      end
    endcase
    res.busy_res = busy_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= '0;
      tx_cnt    <= TX_WAIT_RESET;
      rcv_cnt   <= RECEIVE_RESET;
      rx_cnt    <= RX_WAIT_RESET;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        busy    <= busy_next;
        idx     <= idx_next;
        tx_cnt  <= tx_cnt_next;
        rcv_cnt <= rcv_cnt_next;
        rx_cnt  <= rx_cnt_next;
      end
      if (q_pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // frame shifter and result register carry data only
  always_ff @(posedge clk) begin
    if (q_pop) begin
      frame    <= frame_next;
      out_data <= res;
    end
  end

endmodule

/* rtl/dali_forward_frame_transmitter.sv */
// Manchester forward frame transmitter, one result word per input word.
//
// Input stream (s_*): one word is a tick or a send request. tdata holds
// command, target_addr and payload. A send request while idle builds a
// 56 half-bit frame and drives its first half-bit; each later tick drives
// the next half-bit, then counts down the tx wait, receive window and
// rx wait periods before going idle. A request while busy is rejected.
// Output stream (m_*): one word for every input word, in order.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 tx wait, 1 receive window, 2 rx wait); other indexes are ignored.
//
// Throughput is one word per cycle while m_tready is high: a 2-entry
// queue sits between the input decoder and the frame sequencer, and the
// sequencer's output register is refilled in the same cycle it is taken.
// When m_tready is low the output word holds, the queue fills and then
// s_tready drops. Reset clears the queue and output valid, loads the
// register defaults (20, 24, 6) and leaves the block idle.
module dali_forward_frame_transmitter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [1:0] command, [9:2] target_addr, [25:10] payload, rest zero
  input  logic [dff_pkg::IN_W-1:0]      s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [0] line_level, [1] line_written, [2] status, [3] busy_res, rest zero
  output logic [dff_pkg::OUT_W-1:0]     m_tdata,
  input  logic                          cfg_we,
  input  logic [dff_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dff_pkg::CNT_W-1:0]     cfg_data
);
  import dff_pkg::*;

  entry_t  push_entry;
  entry_t  pop_entry;
  logic    q_full;
  logic    q_empty;
  logic    q_pop;
  logic    push;
  result_t res;

  assign s_tready = !q_full;
  assign push     = s_tvalid && s_tready;

  dff_front u_front (
    .command     (s_tdata[1:0]),
    .target_addr (s_tdata[9:2]),
    .payload     (s_tdata[25:10]),
    .entry       (push_entry)
  );

  dff_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_entry),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_entry),
    .empty     (q_empty)
  );

  dff_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_empty   (q_empty),
    .q_data    (pop_entry),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (res)
  );

  assign m_tdata = {4'd0, res};

`ifndef SYNTHESIS
  a_level_needs_write: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1] || !m_tdata[0]))
    else $error("line level high with no half-bit driven");

  a_reject_no_write: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[2] && m_tdata[1]))
    else $error("rejected request drove the line");

  a_reject_while_busy: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[2]) |-> m_tdata[3])
    else $error("request rejected while idle");
`endif

endmodule
